/* sv/mexp_pkg.sv */
// shared types and constants for the modular exponentiation block
// no dependencies; imported by mexp_div and modular_exponentiation
package mexp_pkg;

    localparam int MOD_WIDTH_DEF = 31;
    localparam int EXP_WIDTH_DEF = 32;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_PRIME   = 2'd1;
    localparam logic [1:0] ST_NOT_COPRIME = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_PR_MUL,
        S_PR_CMP,
        S_PR_WAIT,
        S_NORM,
        S_NORM_WAIT,
        S_GCD,
        S_GCD_WAIT,
        S_EXPRED,
        S_EXPRED_WAIT,
        S_PW_STEP,
        S_PW_ACC_DIV,
        S_PW_ACC_WAIT,
        S_PW_SQ_DIV,
        S_PW_SQ_WAIT,
        S_DONE
    } state_t;

endpackage

/* sv/modular_exponentiation.sv */
// top level: sequencer, shared multiplier and operand registers
// depends on mexp_pkg and mexp_div
//
// usage: drive base, exponent and modulus and pulse start while busy is low;
// the beat is taken at that edge and busy stays high until the result
// leaves. the result appears on power and status for exactly one cycle
// with done high; the receiver cannot stall it.
// cfg_we/cfg_data write fermat_mode (reset 0); write only while idle.
// every modular reduction runs through one remainder unit that walks
// D = max(2*MOD_WIDTH, EXP_WIDTH, 32) dividend bits.
// plain mode: one reduction for the base, then per exponent bit a square
// and, for a set bit, a multiply.
// fermat mode adds odd trial division, one reduction per odd divisor up to
// sqrt(modulus), a gcd of a few dozen reductions and one exponent reduction.
// reset clears the sequencer and the register; no result is pending.
module modular_exponentiation #(
    parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF,
    parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  cfg_we,
    input  logic                  cfg_data,
    input  logic signed [31:0]    base,
    input  logic [EXP_WIDTH-1:0]  exponent,
    input  logic [MOD_WIDTH-1:0]  modulus,
    output logic                  done,
    output logic [MOD_WIDTH-1:0]  power,
    output logic [1:0]            status
);
    import mexp_pkg::*;

    localparam int W1    = (2 * MOD_WIDTH > EXP_WIDTH) ? 2 * MOD_WIDTH : EXP_WIDTH;
    localparam int DIV_W = (W1 > 32) ? W1 : 32;
    localparam int PW    = 2 * MOD_WIDTH;

    state_t state_reg, state_next;

    logic                 fermat_reg;
    logic                 mode_reg, mode_next;
    logic [31:0]          raw_reg, raw_next;
    logic [EXP_WIDTH-1:0] e_reg, e_next;
    logic [MOD_WIDTH-1:0] m_reg, m_next;
    logic [MOD_WIDTH-1:0] b_reg, b_next;
    logic [MOD_WIDTH-1:0] acc_reg, acc_next;
    logic [MOD_WIDTH-1:0] d_reg, d_next;
    logic [MOD_WIDTH-1:0] u_reg, u_next;
    logic [MOD_WIDTH-1:0] v_reg, v_next;
    logic [MOD_WIDTH-1:0] pow_reg, pow_next;
    logic [1:0]           st_reg, st_next;
    logic [PW-1:0]        prod_reg;
    logic [MOD_WIDTH-1:0] mul_a, mul_b;

    logic                 div_start;
    logic [DIV_W-1:0]     div_dvd;
    logic [MOD_WIDTH-1:0] div_dsr;
    logic                 div_done;
    logic [MOD_WIDTH-1:0] div_rem;
    logic [MOD_WIDTH-1:0] norm_r;
    logic                 neg;
    logic [31:0]          base_mag;

    mexp_div #(
        .MOD_WIDTH (MOD_WIDTH),
        .DIV_W     (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign neg = raw_reg[31];
    // magnitude of a negative base fits 32 bits, even for the minimum
    assign base_mag = ~raw_reg + 32'd1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (start)
                    state_next = S_CHECK;
            S_CHECK:
                if (mode_reg)
                begin
                    if (m_reg < MOD_WIDTH'(2))
                        state_next = S_DONE;
                    else if (m_reg == MOD_WIDTH'(2))
                        state_next = S_NORM;
                    else if (!m_reg[0])
                        state_next = S_DONE;
                    else
                        state_next = S_PR_MUL;
                end
                else if (m_reg == '0)
                    state_next = S_DONE;
                else
                    state_next = S_NORM;
            S_PR_MUL:
                state_next = S_PR_CMP;
            S_PR_CMP:
                if (prod_reg > PW'(m_reg))
                    state_next = S_NORM;
                else
                    state_next = S_PR_WAIT;
            S_PR_WAIT:
                if (div_done)
                    state_next = (div_rem == '0) ? S_DONE : S_PR_MUL;
            S_NORM:
                state_next = S_NORM_WAIT;
            S_NORM_WAIT:
                if (div_done)
                    state_next = mode_reg ? S_GCD : S_PW_STEP;
            S_GCD:
                if (v_reg == '0)
                    state_next = (u_reg == MOD_WIDTH'(1)) ? S_EXPRED : S_DONE;
                else
                    state_next = S_GCD_WAIT;
            S_GCD_WAIT:
                if (div_done)
                    state_next = S_GCD;
            S_EXPRED:
                state_next = S_EXPRED_WAIT;
            S_EXPRED_WAIT:
                if (div_done)
                    state_next = S_PW_STEP;
            S_PW_STEP:
                if (e_reg == '0)
                    state_next = S_DONE;
                else if (e_reg[0])
                    state_next = S_PW_ACC_DIV;
                else
                    state_next = S_PW_SQ_DIV;
            S_PW_ACC_DIV:
                state_next = S_PW_ACC_WAIT;
            S_PW_ACC_WAIT:
                if (div_done)
                    state_next = S_PW_SQ_DIV;
            S_PW_SQ_DIV:
                state_next = S_PW_SQ_WAIT;
            S_PW_SQ_WAIT:
                if (div_done)
                    state_next = S_PW_STEP;
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        mode_next = mode_reg;
        raw_next  = raw_reg;
        e_next    = e_reg;
        m_next    = m_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        d_next    = d_reg;
        u_next    = u_reg;
        v_next    = v_reg;
        pow_next  = pow_reg;
        st_next   = st_reg;
        div_start = 1'b0;
        div_dvd   = DIV_W'(prod_reg);
        div_dsr   = m_reg;
        norm_r    = div_rem;
        if (neg && div_rem != '0)
            norm_r = m_reg - div_rem;
        mul_a = b_reg;
        mul_b = b_reg;
        case (state_reg)
            S_IDLE:
                if (start)
                begin
                    mode_next = fermat_reg;
                    raw_next  = base;
                    e_next    = exponent;
                    m_next    = modulus;
                    pow_next  = '0;
                    st_next   = ST_OK;
                end
            S_CHECK:
            begin
                d_next = MOD_WIDTH'(3);
                if (mode_reg && (m_reg < MOD_WIDTH'(2) ||
                                 (m_reg != MOD_WIDTH'(2) && !m_reg[0])))
                    st_next = ST_NOT_PRIME;
            end
            S_PR_MUL:
            begin
                mul_a = d_reg;
                mul_b = d_reg;
            end
            S_PR_CMP:
                if (prod_reg <= PW'(m_reg))
                begin
                    div_start = 1'b1;
                    div_dvd   = DIV_W'(m_reg);
                    div_dsr   = d_reg;
                end
            S_PR_WAIT:
                if (div_done)
                begin
                    if (div_rem == '0)
                        st_next = ST_NOT_PRIME;
                    d_next = d_reg + MOD_WIDTH'(2);
                end
            S_NORM:
            begin
                div_start = 1'b1;
                div_dvd   = neg ? DIV_W'(base_mag) : DIV_W'(raw_reg);
            end
            S_NORM_WAIT:
                if (div_done)
                begin
                    b_next   = norm_r;
                    acc_next = MOD_WIDTH'(1);
                    u_next   = m_reg;
                    v_next   = norm_r;
                end
            S_GCD:
                if (v_reg == '0)
                begin
                    if (u_reg != MOD_WIDTH'(1))
                        st_next = ST_NOT_COPRIME;
                end
                else
                begin
                    div_start = 1'b1;
                    div_dvd   = DIV_W'(u_reg);
                    div_dsr   = v_reg;
                end
            S_GCD_WAIT:
                if (div_done)
                begin
                    u_next = v_reg;
                    v_next = div_rem;
                end
            S_EXPRED:
            begin
                div_start = 1'b1;
                div_dvd   = DIV_W'(e_reg);
                div_dsr   = m_reg - MOD_WIDTH'(1);
            end
            S_EXPRED_WAIT:
                if (div_done)
                    e_next = EXP_WIDTH'(div_rem);
            S_PW_STEP:
            begin
                if (e_reg[0])
                    mul_a = acc_reg;
                if (e_reg == '0)
                    pow_next = acc_reg;
            end
            S_PW_ACC_DIV:
                div_start = 1'b1;
            S_PW_ACC_WAIT:
                if (div_done)
                    acc_next = div_rem;
            S_PW_SQ_DIV:
                div_start = 1'b1;
            S_PW_SQ_WAIT:
                if (div_done)
                begin
                    b_next = div_rem;
                    e_next = e_reg >> 1;
                end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fermat_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                fermat_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        raw_reg  <= raw_next;
        e_reg    <= e_next;
        m_reg    <= m_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        d_reg    <= d_next;
        u_reg    <= u_next;
        v_reg    <= v_next;
        pow_reg  <= pow_next;
        st_reg   <= st_next;
        prod_reg <= PW'(mul_a) * PW'(mul_b);
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = (state_reg == S_DONE);
    assign power  = pow_reg;
    assign status = st_reg;

endmodule

/* sv/mexp_div.sv */
// restoring remainder unit, one dividend bit per cycle
// depends on mexp_pkg (imported for house consistency)
module mexp_div #(
    parameter int MOD_WIDTH = 31,
    parameter int DIV_W     = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_W-1:0]     dividend,
    input  logic [MOD_WIDTH-1:0] divisor,
    output logic                 done,
    output logic [MOD_WIDTH-1:0] rem
);
    import mexp_pkg::*;

    localparam int CW = $clog2(DIV_W + 1);

    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [DIV_W-1:0]     dvd_reg, dvd_next;
    logic [MOD_WIDTH-1:0] rem_reg, rem_next;
    logic [MOD_WIDTH-1:0] dsr_reg, dsr_next;
    logic [MOD_WIDTH:0]   trial;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, dvd_reg[DIV_W-1]};
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CW'(DIV_W);
            dvd_next = dividend;
            dsr_next = divisor;
            rem_next = '0;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
                rem_next = MOD_WIDTH'(trial - {1'b0, dsr_reg});
            else
                rem_next = trial[MOD_WIDTH-1:0];
            dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule
